@@ rtl/lzwbc_pkg.sv @@
`default_nettype none

package lzwbc_pkg;

   localparam int DICT_ENTRIES = 4096;
   localparam int BYTE_W       = 8;
   localparam int OUT_W        = 12;
   localparam int CODE_W       = $clog2(DICT_ENTRIES);
   localparam int NF_W         = $clog2(DICT_ENTRIES + 1);
   // hash table has at least twice as many slots as codes, so probing always ends
   localparam int SLOT_W       = CODE_W + 1;
   localparam int SLOT_COUNT   = 1 << SLOT_W;
   localparam int FIRST_FREE   = 256;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [OUT_W-1:0]  out_code_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [NF_W-1:0]   nf_type;
   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      code_type prefix;
      byte_type data;
      slot_type slot;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT,
      ST_ENTRY,
      ST_CHECK,
      ST_EMIT_MISS,
      ST_EMIT_LAST
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic probe_next;
      logic take_hit;
      logic emit_miss;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic present;
      logic req_last;
      logic last;
      logic live;
      logic key_match;
      logic out_free;
   } stat_type;

   function automatic slot_type hash_slot(code_type prefix, byte_type data);
      return slot_type'(prefix) ^ (slot_type'(data) << (SLOT_W - BYTE_W));
   endfunction

endpackage

`default_nettype wire

@@ rtl/lzwbc_ctrl.sv @@
`default_nettype none

module lzwbc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lzwbc_pkg::stat_type stat,
   output lzwbc_pkg::cmd_type       cmd
);

   lzwbc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzwbc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzwbc_pkg::ST_CLEAR: begin
            if (stat.clear_done) state_in = lzwbc_pkg::ST_IDLE;
         end
         lzwbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (stat.present)       state_in = lzwbc_pkg::ST_SLOT;
               else if (stat.req_last) state_in = lzwbc_pkg::ST_EMIT_LAST;
            end
         end
         lzwbc_pkg::ST_SLOT:  state_in = lzwbc_pkg::ST_ENTRY;
         lzwbc_pkg::ST_ENTRY: state_in = lzwbc_pkg::ST_CHECK;
         lzwbc_pkg::ST_CHECK: begin
            if (stat.live && stat.key_match)
               state_in = stat.last ? lzwbc_pkg::ST_EMIT_LAST : lzwbc_pkg::ST_IDLE;
            else if (!stat.live)
               state_in = lzwbc_pkg::ST_EMIT_MISS;
            else
               state_in = lzwbc_pkg::ST_SLOT;
         end
         lzwbc_pkg::ST_EMIT_MISS: begin
            if (stat.out_free)
               state_in = stat.last ? lzwbc_pkg::ST_EMIT_LAST : lzwbc_pkg::ST_IDLE;
         end
         lzwbc_pkg::ST_EMIT_LAST: begin
            if (stat.out_free) state_in = lzwbc_pkg::ST_IDLE;
         end
         default: state_in = lzwbc_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lzwbc_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         lzwbc_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         lzwbc_pkg::ST_SLOT, lzwbc_pkg::ST_ENTRY: ;
         lzwbc_pkg::ST_CHECK: begin
            cmd.take_hit   = stat.live && stat.key_match;
            cmd.probe_next = stat.live && !stat.key_match;
         end
         lzwbc_pkg::ST_EMIT_MISS: cmd.emit_miss = stat.out_free;
         lzwbc_pkg::ST_EMIT_LAST: cmd.emit_last = stat.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/lzwbc_dpath.sv @@
`default_nettype none

module lzwbc_dpath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lzwbc_pkg::cmd_type      cmd,
   output lzwbc_pkg::stat_type          stat,
   input  wire lzwbc_pkg::byte_type     req_data_byte,
   input  wire logic                    req_end_of_message,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output lzwbc_pkg::out_code_type      rsp_code_word,
   output logic                         rsp_final_code
);

   // slot table: hash slot -> code; entry table: code -> (prefix, byte, home slot)
   lzwbc_pkg::code_type  slot_mem [lzwbc_pkg::SLOT_COUNT];
   lzwbc_pkg::entry_type entry_mem [lzwbc_pkg::DICT_ENTRIES];

   lzwbc_pkg::code_type     slot_code_ff;
   lzwbc_pkg::entry_type    entry_ff;

   lzwbc_pkg::byte_type     byte_ff, byte_in;
   logic                    last_ff, last_in;
   lzwbc_pkg::code_type     prefix_ff, prefix_in;
   logic                    present_ff, present_in;
   lzwbc_pkg::nf_type       next_free_ff, next_free_in;
   lzwbc_pkg::slot_type     probe_ff, probe_in;
   logic                    out_valid_ff, out_valid_in;
   lzwbc_pkg::out_code_type out_code_ff, out_code_in;
   logic                    out_final_ff, out_final_in;

   logic full;
   logic insert;

   assign full   = (next_free_ff == lzwbc_pkg::nf_type'(lzwbc_pkg::DICT_ENTRIES));
   assign insert = cmd.emit_miss && !full;

   always_ff @(posedge clock) begin
      if (cmd.clear_step || insert) begin
         slot_mem[probe_ff] <= cmd.clear_step ? '0 : lzwbc_pkg::code_type'(next_free_ff);
      end
      slot_code_ff <= slot_mem[probe_ff];
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         entry_mem[next_free_ff[lzwbc_pkg::CODE_W-1:0]] <= '{prefix_ff, byte_ff, probe_ff};
      end
      entry_ff <= entry_mem[slot_code_ff];
   end

   // a slot is live only if its code was handed out in this message and points back here
   always_comb begin
      stat.clear_done = (probe_ff == lzwbc_pkg::slot_type'(lzwbc_pkg::SLOT_COUNT - 1));
      stat.present    = present_ff;
      stat.req_last   = req_end_of_message;
      stat.last       = last_ff;
      stat.live       = (slot_code_ff >= lzwbc_pkg::code_type'(lzwbc_pkg::FIRST_FREE))
                        && (lzwbc_pkg::nf_type'(slot_code_ff) < next_free_ff)
                        && (entry_ff.slot == probe_ff);
      stat.key_match  = (entry_ff.prefix == prefix_ff) && (entry_ff.data == byte_ff);
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      byte_in      = byte_ff;
      last_in      = last_ff;
      prefix_in    = prefix_ff;
      present_in   = present_ff;
      next_free_in = next_free_ff;
      probe_in     = probe_ff;
      out_code_in  = out_code_ff;
      out_final_in = out_final_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (cmd.clear_step || cmd.probe_next) begin
         probe_in = probe_ff + lzwbc_pkg::slot_type'(1);
      end
      if (cmd.accept) begin
         byte_in  = req_data_byte;
         last_in  = req_end_of_message;
         probe_in = lzwbc_pkg::hash_slot(prefix_ff, req_data_byte);
         if (!present_ff) begin
            prefix_in  = lzwbc_pkg::code_type'(req_data_byte);
            present_in = 1'b1;
         end
      end
      if (cmd.take_hit) begin
         prefix_in = slot_code_ff;
      end
      if (cmd.emit_miss) begin
         out_valid_in = 1'b1;
         out_code_in  = lzwbc_pkg::out_code_type'(prefix_ff);
         out_final_in = 1'b0;
         prefix_in    = lzwbc_pkg::code_type'(byte_ff);
         if (!full) next_free_in = next_free_ff + lzwbc_pkg::nf_type'(1);
      end
      if (cmd.emit_last) begin
         out_valid_in = 1'b1;
         out_code_in  = lzwbc_pkg::out_code_type'(prefix_ff);
         out_final_in = 1'b1;
         prefix_in    = '0;
         present_in   = 1'b0;
         next_free_in = lzwbc_pkg::nf_type'(lzwbc_pkg::FIRST_FREE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= '0;
         present_ff   <= 1'b0;
         next_free_ff <= lzwbc_pkg::nf_type'(lzwbc_pkg::FIRST_FREE);
         probe_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prefix_ff    <= prefix_in;
         present_ff   <= present_in;
         next_free_ff <= next_free_in;
         probe_ff     <= probe_in;
         out_valid_ff <= out_valid_in;
      end
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      out_code_ff  <= out_code_in;
      out_final_ff <= out_final_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_word  = out_code_ff;
   assign rsp_final_code = out_final_ff;

endmodule

`default_nettype wire

@@ rtl/lzw_byte_compressor_unit.sv @@
`default_nettype none

// LZW byte compressor. One byte per req item (req_data_byte, req_end_of_message marks
// the last byte of a message); rsp items carry 12-bit codes, rsp_final_code on the last
// code of a message. An item yields zero, one or two codes.
// Lookup is a hash table probed linearly: each probe reads the slot table, then the
// entry table, then compares, in states SLOT, ENTRY and CHECK. The first byte of a
// message only loads the prefix in IDLE; any other byte takes one probe, plus one more
// for each collision, and on a miss its code is then loaded in EMIT_MISS.
// A final code is loaded in EMIT_LAST: after the miss code, after the probes of a hit,
// or straight from IDLE for a single-byte message.
// Results sit in an output register; the next byte is accepted while a code waits
// there. A stalled receiver holds up the block only once a new code must be loaded.
// After reset the slot table is swept to zero, one slot a cycle, across all
// 2^(clog2(DICT_ENTRIES)+1) slots (8192 at 4096 entries); req_ready stays low
// meanwhile. Reset also clears the pending prefix and the free-code counter, and the
// dictionary empties again after every final code.
module lzw_byte_compressor_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_message,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [11:0]     rsp_code_word,
   output logic            rsp_final_code
);

   lzwbc_pkg::cmd_type  cmd;
   lzwbc_pkg::stat_type stat;

   lzwbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lzwbc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_word      (rsp_code_word),
      .rsp_final_code     (rsp_final_code)
   );

endmodule

`default_nettype wire

@@ rtl/lzwbc_checker.sv @@
`default_nettype none

module lzwbc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_end_of_message,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [11:0] rsp_code_word,
   input wire logic        rsp_final_code
);

   // the clearing sweep follows reset: nothing in, nothing out
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity right after reset");

   // the last byte of a message always leaves at least one code to produce
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_message) |=> !req_ready)
      else $error("ready right after a final byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_code_word) && $stable(rsp_final_code)))
      else $error("rsp payload changed while stalled");

endmodule

bind lzw_byte_compressor_unit lzwbc_checker u_lzwbc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_end_of_message (req_end_of_message),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_code_word      (rsp_code_word),
   .rsp_final_code     (rsp_final_code)
);

`default_nettype wire
